FILE: sv/assert_macros.svh
// assert_macros.svh - assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, a, c)
`define ASSERT_NEXT(label, a, c)
`endif
`endif

FILE: sv/totp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// totp_pkg
// Shared types and constants of the one-time password generator.
// ----------------------------------------------------------------------------
package totp_pkg;
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_TIME = 2'd1;
	localparam logic [1:0] CMD_CNT  = 2'd2;

	localparam logic [1:0] REG_KEY_LEN = 2'd0;
	localparam logic [1:0] REG_STEP    = 2'd1;
	localparam logic [1:0] REG_ORIGIN  = 2'd2;

	localparam logic [31:0] OTP_MOD = 32'd1000000;

	// 10^6 = 64 * 15625; floor(x / 15625) for x below 2^25 is
	// (x * OTP_RECIP) >> OTP_SHIFT
	localparam logic [25:0] OTP_RECIP = 26'd35184373;
	localparam int          OTP_SHIFT = 39;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_KEYRD, ST_KEYWT, ST_SHA, ST_SHAWT,
		ST_TRUNC, ST_MOD, ST_OUT
	} state_t;

	// control from the sequencer to the compression unit
	typedef struct packed {
		logic start;   // begin a block, chaining values loaded from h_in
		logic init;    // chaining values from the SHA-1 initial vector
	} sha_ctl_t;

	function automatic logic [31:0] sha_k(input logic [6:0] r);
		if (r < 7'd20) return 32'h5A827999;
		else if (r < 7'd40) return 32'h6ED9EBA1;
		else if (r < 7'd60) return 32'h8F1BBCDC;
		else return 32'hCA62C1D6;
	endfunction
endpackage

FILE: sv/totp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// totp_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module totp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

FILE: sv/totp_sha1.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// totp_sha1
// SHA-1 compression, one round per cycle, 16-word rolling schedule.
// ----------------------------------------------------------------------------
module totp_sha1 (
	input  logic               clk,
	input  logic               arst_n,
	input  totp_pkg::sha_ctl_t ctl,
	input  logic [159:0]       h_in,
	input  logic [511:0]       blk,
	output logic [159:0]       h_out,
	output logic               done
);
	import totp_pkg::*;

	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [159:0] h_q;
	logic [511:0] w_q;
	logic [6:0] rnd_q;
	logic busy_q;
	logic [31:0] f, t, wn, w0;

	// w_q[511:480] is the current schedule word
	assign w0 = w_q[511:480];
	assign wn = {w_q[511-13*32 -: 32] ^ w_q[511-8*32 -: 32] ^ w_q[511-2*32 -: 32] ^ w0};

	always_comb begin
		if (rnd_q < 7'd20) f = (b_q & c_q) | (~b_q & d_q);
		else if (rnd_q < 7'd40 || rnd_q >= 7'd60) f = b_q ^ c_q ^ d_q;
		else f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
		t = {a_q[26:0], a_q[31:27]} + f + e_q + sha_k(rnd_q) + w0;
	end

	assign h_out = h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				if (rnd_q == 7'd79) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				rnd_q <= rnd_q + 7'd1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			logic [159:0] hv;
			hv = ctl.init ? 160'h67452301EFCDAB8998BADCFE10325476C3D2E1F0 : h_in;
			h_q <= hv;
			{a_q, b_q, c_q, d_q, e_q} <= hv;
			w_q <= blk;
		end else if (busy_q) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t;
			w_q <= {w_q[479:0], wn[30:0], wn[31]};
			if (rnd_q == 7'd79)
				h_q <= {h_q[159:128] + t, h_q[127:96] + a_q,
					h_q[95:64] + {b_q[1:0], b_q[31:2]}, h_q[63:32] + c_q,
					h_q[31:0] + d_q};
		end
	end
endmodule

FILE: sv/totp_hmac_sha1_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// totp_hmac_sha1_generator_core
// TOTP/HOTP generator: key store, counter divider, HMAC-SHA1, truncation.
// ----------------------------------------------------------------------------
// In time mode a generate transfer runs through the restoring division of
// (time - origin) by the step, the key-store reads for each padded-key block
// (through the registered RAM read), four SHA-1 compressions (start, 80 rounds,
// done) on the one shared round unit, and then truncation, the reciprocal
// mod-10^6 reduction and the result load. Counter mode skips the division; a
// time before the origin goes straight to its flagged result. The block
// accepts no transfer while a generation runs; one result register holds the
// answer until the output side takes it.
`include "assert_macros.svh"
module totp_hmac_sha1_generator_core #(
	parameter int KEY_MAX_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // command[1:0], key_index[7:2], key_byte[15:8],
	                               // time_or_counter[79:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [119:0] m_tdata,  // otp_code[19:0], truncated_code[50:20],
	                               // counter_used[114:51], before_origin[115]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import totp_pkg::*;

	localparam int AW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

	state_t state_q, state_n;
	logic [6:0]  key_len_q;
	logic [15:0] step_q;
	logic [63:0] origin_q;
	logic [63:0] cnt_q, rem_q;
	logic [6:0]  idx_q;
	logic [1:0]  blk_q;
	logic [511:0] blk_buf_q;
	logic [159:0] hin_q, inner_q;
	logic [31:0] code_q, modr_q;
	logic [50:0] prod_q;
	logic        bo_q;
	logic        m_valid_q;
	logic [119:0] res_q;
	sha_ctl_t    sctl;
	logic [159:0] h_out;
	logic        sdone;
	logic [7:0]  kbyte;
	logic [6:0]  klen;

	logic [1:0]  in_cmd;
	logic [5:0]  in_idx;
	logic [7:0]  in_byte;
	logic [63:0] in_tc;
	assign in_cmd  = s_tdata[1:0];
	assign in_idx  = s_tdata[7:2];
	assign in_byte = s_tdata[15:8];
	assign in_tc   = s_tdata[79:16];

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE) && !m_valid_q;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = res_q;

	assign klen = (key_len_q > 7'(KEY_MAX_BYTES)) ? 7'(KEY_MAX_BYTES) : key_len_q;

	logic we;
	assign we = s_tvalid && s_tready && in_cmd == CMD_LOAD
		&& ({1'b0, in_idx} < 7'(KEY_MAX_BYTES));

	totp_ram #(.WIDTH(8), .DEPTH(KEY_MAX_BYTES)) u_key (
		.clk(clk), .we(we), .waddr(in_idx[AW-1:0]), .wdata(in_byte),
		.raddr(idx_q[AW-1:0]), .rdata(kbyte)
	);

	totp_sha1 u_sha (
		.clk(clk), .arst_n(arst_n), .ctl(sctl), .h_in(hin_q),
		.blk(blk_buf_q), .h_out(h_out), .done(sdone)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= '0;
			step_q    <= 16'd30;
			origin_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEY_LEN: key_len_q <= cfg_data[6:0];
				REG_STEP:    step_q    <= cfg_data[15:0];
				REG_ORIGIN:  origin_q  <= cfg_data;
				default:     ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		sctl = '0;
		case (state_q)
			ST_IDLE:
				if (s_tvalid && s_tready) begin
					if (in_cmd == CMD_TIME) begin
						if (in_tc < origin_q) state_n = ST_OUT;
						else state_n = ST_DIV;
					end else if (in_cmd == CMD_CNT) state_n = ST_KEYRD;
				end
			ST_DIV:   if (idx_q == 7'd63) state_n = ST_KEYRD;
			ST_KEYRD: if (idx_q == 7'd64) state_n = ST_SHA;
			ST_SHA: begin
				sctl.start = 1'b1;
				sctl.init  = (blk_q == 2'd0) || (blk_q == 2'd2);
				state_n = ST_SHAWT;
			end
			ST_SHAWT:
				if (sdone) begin
					if (blk_q == 2'd3) state_n = ST_TRUNC;
					else if (blk_q == 2'd1) state_n = ST_KEYRD;
					else state_n = ST_SHA;
				end
			ST_TRUNC: state_n = ST_MOD;
			ST_MOD:   state_n = ST_OUT;
			ST_OUT:   state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_n;
	end

	// result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (state_q == ST_OUT) m_valid_q <= 1'b1;
		else if (m_tready) m_valid_q <= 1'b0;
	end

	// datapath
	logic [64:0] trial;
	logic [15:0] stp;
	logic [63:0] diff;
	logic [7:0]  kb;
	logic [11:0] quo;
	logic [3:0]  off;
	logic [159:0] mac_sh;
	assign stp   = (step_q == 16'd0) ? 16'd1 : step_q;
	assign diff  = in_tc - origin_q;
	assign trial = {rem_q, cnt_q[63]} - {49'd0, stp};
	assign kb    = (idx_q != 7'd0 && (idx_q - 7'd1) < klen) ? kbyte : 8'd0;
	assign quo   = prod_q[OTP_SHIFT +: 12];
	assign off   = h_out[3:0];
	assign mac_sh = h_out << {off, 3'b000};

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cnt_q   <= (in_cmd == CMD_TIME) ? diff : in_tc;
				rem_q   <= '0;
				idx_q   <= '0;
				blk_q   <= '0;
				bo_q    <= (in_cmd == CMD_TIME) && (in_tc < origin_q);
			end
			ST_DIV: begin
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					cnt_q <= {cnt_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[62:0], cnt_q[63]};
					cnt_q <= {cnt_q[62:0], 1'b0};
				end
				idx_q <= (idx_q == 7'd63) ? 7'd0 : idx_q + 7'd1;
			end
			ST_KEYRD: begin
				// one key byte per cycle, read through the registered RAM
				if (idx_q != 7'd0)
					blk_buf_q <= {blk_buf_q[503:0],
						kb ^ ((blk_q == 2'd0) ? 8'h36 : 8'h5C)};
				idx_q <= (idx_q == 7'd64) ? 7'd0 : idx_q + 7'd1;
			end
			ST_SHAWT:
				if (sdone) begin
					hin_q <= h_out;
					blk_q <= blk_q + 2'd1;
					if (blk_q == 2'd0)
						blk_buf_q <= {cnt_q, 8'h80, 376'd0, 64'd576};
					else if (blk_q == 2'd1)
						inner_q <= h_out;
					else if (blk_q == 2'd2)
						blk_buf_q <= {inner_q, 8'h80, 280'd0, 64'd672};
					else
						code_q <= {1'b0, mac_sh[158:128]};
				end
			// quotient by 10^6 through the reciprocal of 15625
			ST_TRUNC: prod_q <= {26'd0, code_q[30:6]} * {25'd0, OTP_RECIP};
			ST_MOD:   modr_q <= code_q - {20'd0, quo} * OTP_MOD;
			ST_OUT:
				if (bo_q) res_q <= {4'd0, 1'b1, 115'd0};
				else res_q <= {4'd0, 1'b0, cnt_q, code_q[30:0], modr_q[19:0]};
			default: ;
		endcase
	end

	`ASSERT_IMPLIES(a_busy_stall, state_q != ST_IDLE, !s_tready)
	`ASSERT_NEXT(a_out_valid, state_q == ST_OUT, m_tvalid)
	`ASSERT_IMPLIES(a_mod_range, m_tvalid, m_tdata[19:0] < 20'd1000000)
	`ASSERT_IMPLIES(a_bo_zero, m_tvalid && m_tdata[115], m_tdata[114:0] == 115'd0)
endmodule
